/* rtl/lkvc_pkg.sv */
// shared types and constants of the lru key/value cache
package lkvc_pkg;

  // field widths of one item
  localparam int KEY_W = 32;
  localparam int VAL_W = 31;
  localparam int CAP_W = 5;

  // capacity register after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  typedef enum logic [0:0] {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_t;

endpackage

/* rtl/lru_key_value_cache_top.sv */
// fully associative key/value cache with least-recently-used replacement
//
//  channel | ports                                     | handshake
//  --------+-------------------------------------------+--------------------------
//  input   | in_kind, in_key, in_value                 | start high, busy low
//  result  | out_hit, out_read_value                   | out_valid, one cycle
//  config  | cfg_data (capacity)                       | cfg_valid and cfg_ready
//
// an item is taken every cycle; its result passes the input register, then a
// parallel key compare and state update into the result register and the value
// ram's read register
// busy stays low and cfg_ready stays high: the receiver cannot stall results
// rst_n is synchronous; it clears valid marks, ranks and count and sets the capacity
// to CAP_RESET (16), no clearing pass is needed
module lru_key_value_cache_top #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_kind,
  input  logic signed [lkvc_pkg::KEY_W-1:0] in_key,
  input  logic [lkvc_pkg::VAL_W-1:0] in_value,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [lkvc_pkg::VAL_W-1:0] out_read_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_data
);

  import lkvc_pkg::*;

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  // input register
  logic             in_valid_r;
  kind_t            kind_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;

  // entry state
  logic [KEY_W-1:0] keys_r   [ENTRIES];
  logic [IW-1:0]    rank_r   [ENTRIES];
  logic [IW-1:0]    rank_nxt [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CAP_W-1:0] cap_r;

  // result register
  logic out_valid_r, out_hit_r, out_sel_r;

  // lookup and replacement signals
  logic [ENTRIES-1:0] hit_oh, oldest_oh, touch_oh;
  logic               hit_any, full, put, get_hit, do_touch, do_fill, key_we;
  logic [IW-1:0]      hit_idx, oldest_idx, slot, hit_rank, touch_rank;
  logic [CW-1:0]      count_m1;
  logic [VAL_W-1:0]   ram_rdata;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // capture the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
    kind_r  <= kind_t'(in_kind);
    key_r   <= $unsigned(in_key);
    value_r <= in_value;
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // parallel compare, oldest entry and slot choice
  always_comb begin
    hit_idx    = '0;
    oldest_idx = '0;
    hit_rank   = '0;
    count_m1   = count_r - CW'(1);
    for (int i = 0; i < ENTRIES; i++) begin
      hit_oh[i]    = valid_r[i] && (keys_r[i] == key_r);
      oldest_oh[i] = valid_r[i] && (CW'(rank_r[i]) == count_m1);
      if (hit_oh[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | rank_r[i];
      end
      if (oldest_oh[i]) begin
        oldest_idx = oldest_idx | IW'(i);
      end
    end
    hit_any = |hit_oh;
    // capacity zero acts as one, capacity above the entry count as the entry count
    full = (count_r == CW'(ENTRIES)) ||
           ((cap_r != '0) && (CMPW'(count_r) >= CMPW'(cap_r))) ||
           ((cap_r == '0) && (count_r != '0));
    put      = in_valid_r && (kind_r == KIND_PUT);
    get_hit  = in_valid_r && (kind_r == KIND_GET) && hit_any;
    do_touch = in_valid_r && (hit_any || (put && full));
    do_fill  = put && !hit_any && !full;
    key_we   = put && !hit_any;
    touch_oh   = hit_any ? hit_oh : oldest_oh;
    touch_rank = hit_any ? hit_rank : count_m1[IW-1:0];
    // entries fill from the bottom and are never dropped, so the free slot is the count
    if (hit_any) begin
      slot = hit_idx;
    end else if (full) begin
      slot = oldest_idx;
    end else begin
      slot = count_r[IW-1:0];
    end
  end

  // recency and valid update
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (do_touch) begin
        if (touch_oh[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < touch_rank)) begin
          rank_nxt[i] = rank_r[i] + IW'(1);
        end
      end else if (do_fill) begin
        if (IW'(i) == slot) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + IW'(1);
        end
      end
    end
    count_nxt = count_r + CW'(do_fill);
  end

  // entry state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (key_we && (IW'(i) == slot)) begin
        keys_r[i] <= key_r;
      end
    end
  end

  // value store, read at the hit entry
  lkvc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ENTRIES)
  ) u_values (
    .clk   (clk),
    .we    (put),
    .waddr (slot),
    .wdata (value_r),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
    out_hit_r <= hit_any;
    out_sel_r <= get_hit;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_sel_r ? ram_rdata : '0;

  // at most one entry holds the key
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |-> $onehot0(hit_oh))
    else $error("key found in more than one entry");

  // an eviction always finds exactly one oldest entry
  a_oldest_found: assert property (@(posedge clk) disable iff (!rst_n)
    (put && !hit_any && full) |-> $onehot(oldest_oh))
    else $error("no unique least recent entry on eviction");

  // occupied count matches the valid marks
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    CW'($countones(valid_r)) == count_r)
    else $error("occupied count out of step with valid marks");

  // every accepted item yields a result through the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result missing for an accepted item");

endmodule

/* rtl/lkvc_ram.sv */
// generic single write port ram with registered read
module lkvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
